// File: rtl/assert_macros.svh
// Assertion macros shared by the translator RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dpat_pkg.sv
// Shared widths, limits and beat types of the address translator.
// No dependencies.
package dpat_pkg;

  localparam int ADDR_W  = 16;
  localparam int PHYS_W  = 15;
  localparam int EVICT_W = 8;
  localparam int COUNT_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [ADDR_W-1:0] logical_address;
  } lookup_t;

  typedef struct packed {
    logic [PHYS_W-1:0]  physical_address;
    logic               page_fault;
    logic               evicted_valid;
    logic [EVICT_W-1:0] evicted_page;
    logic [COUNT_W-1:0] fault_total;
  } result_t;

endpackage

// File: rtl/dpat_stream_if.sv
// Valid/ready stream channel carrying one beat of a chosen type.
// Beat types come from dpat_pkg.
interface dpat_stream_if #(
  parameter type beat_t = logic
) ();
  logic  valid;
  logic  ready;
  beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/demand_paged_address_translator_top.sv
// Demand-paged address translator with FIFO frame replacement.
// Uses dpat_pkg, dpat_stream_if, dpat_page_mod, dpat_ram and assert_macros.svh.
//
// lookup carries one 16-bit logical address per beat; result returns one beat per
// lookup with the physical address, fault flag, evicted page and fault total.
// Pipeline: two stages reduce the page number, one stage reads the page table
// and the frame-owner map, then the result is written into an output register.
// Throughput is one lookup per cycle while the result receiver does not stall,
// for hits and for faults that take a free frame; a fault that evicts a mapped
// page then holds the page-table write port to invalidate that page, and the
// lookups behind it wait for that write.
// Same-cycle read/write collisions on either memory are forwarded.
// After reset both memories are swept invalid, one entry a cycle, until every
// entry of the larger memory is cleared; lookup.ready stays low during the
// sweep. The victim pointer and fault total reset to zero.
// When the result receiver stalls, the output register holds its beat; the
// pipeline keeps filling until the lookup in the last stage has nowhere to go,
// then lookup.ready drops.
`include "assert_macros.svh"

module demand_paged_address_translator_top #(
  parameter int PAGE_COUNT   = 256,
  parameter int FRAME_COUNT  = 128,
  parameter int OFFSET_WIDTH = 8
) (
  input logic            clk,
  input logic            rst,
  dpat_stream_if.sink    lookup,
  dpat_stream_if.source  result
);

  localparam int PW    = $clog2(PAGE_COUNT);
  localparam int FW    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int OW    = OFFSET_WIDTH;
  localparam int CLR_N = (PAGE_COUNT > FRAME_COUNT) ? PAGE_COUNT : FRAME_COUNT;
  localparam int CW    = $clog2(CLR_N);
  localparam int PHW   = dpat_pkg::PHYS_W + FW + OW;
  localparam int EVW   = dpat_pkg::EVICT_W + PW;

  logic                         clearing;
  logic [CW-1:0]                clr_idx;

  logic                         v1, v2, vw;
  logic [OW-1:0]                offset, off1, off2, offw;
  logic [dpat_pkg::ADDR_W-1:0]  page_field;
  logic [PW-1:0]                page_r, page_w;

  logic [FW-1:0]                victim, victim_inc, victim_rd;
  logic [dpat_pkg::COUNT_W-1:0] fault_count, fault_inc;
  logic                         inv_phase;
  logic [PW-1:0]                inv_page;

  logic                         pm_we;
  logic [PW-1:0]                pm_waddr;
  logic [FW:0]                  pm_wdata, pm_rdata, pm_e, fwd_pm_data;
  logic                         fo_we;
  logic [FW-1:0]                fo_waddr;
  logic [PW:0]                  fo_wdata, fo_rdata, fo_e, fwd_fo_data;
  logic                         fwd_pm_hit, fwd_fo_hit;

  logic                         hit, evict, out_free, wload, w_done, adv;
  logic [FW-1:0]                w_frame;
  logic [PW-1:0]                old_page;
  logic [PHW-1:0]               phys_wide;
  logic [EVW-1:0]               evict_wide;

  logic                         ov;
  dpat_pkg::result_t            out_q;

  assign offset     = lookup.data.logical_address[OW-1:0];
  assign page_field = lookup.data.logical_address >> OFFSET_WIDTH;

  dpat_page_mod #(
    .PAGE_COUNT (PAGE_COUNT),
    .PW         (PW)
  ) u_page_mod (
    .clk        (clk),
    .en         (adv),
    .page_field (page_field),
    .page       (page_r)
  );

  dpat_ram #(
    .DEPTH (PAGE_COUNT),
    .WIDTH (FW + 1),
    .AW    (PW)
  ) u_page_map (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .re    (adv),
    .raddr (page_r),
    .rdata (pm_rdata)
  );

  dpat_ram #(
    .DEPTH (FRAME_COUNT),
    .WIDTH (PW + 1),
    .AW    (FW)
  ) u_frame_owner (
    .clk   (clk),
    .we    (fo_we),
    .waddr (fo_waddr),
    .wdata (fo_wdata),
    .re    (adv),
    .raddr (victim_rd),
    .rdata (fo_rdata)
  );

  always_comb begin
    pm_e       = fwd_pm_hit ? fwd_pm_data : pm_rdata;
    fo_e       = fwd_fo_hit ? fwd_fo_data : fo_rdata;
    hit        = pm_e[FW];
    evict      = !hit && fo_e[PW];
    old_page   = fo_e[PW-1:0];
    w_frame    = hit ? pm_e[FW-1:0] : victim;
    out_free   = !ov || result.ready;
    wload      = vw && !inv_phase && out_free;
    w_done     = (vw && inv_phase) || (wload && !evict);
    adv        = !clearing && (!vw || w_done);
    victim_inc = (victim == FW'(FRAME_COUNT - 1)) ? '0 : victim + 1'b1;
    victim_rd  = (wload && !hit) ? victim_inc : victim;
    fault_inc  = (fault_count == dpat_pkg::COUNT_MAX) ? fault_count : fault_count + 1'b1;
    phys_wide  = {{dpat_pkg::PHYS_W{1'b0}}, w_frame, offw};
    evict_wide = {{dpat_pkg::EVICT_W{1'b0}}, old_page};
  end

  always_comb begin
    pm_we    = 1'b0;
    pm_waddr = page_w;
    pm_wdata = {1'b1, victim};
    if (clearing) begin
      pm_we    = int'(clr_idx) < PAGE_COUNT;
      pm_waddr = clr_idx[PW-1:0];
      pm_wdata = '0;
    end else if (vw && inv_phase) begin
      pm_we    = 1'b1;
      pm_waddr = inv_page;
      pm_wdata = '0;
    end else if (wload && !hit) begin
      pm_we    = 1'b1;
    end
  end

  always_comb begin
    fo_we    = 1'b0;
    fo_waddr = victim;
    fo_wdata = {1'b1, page_w};
    if (clearing) begin
      fo_we    = int'(clr_idx) < FRAME_COUNT;
      fo_waddr = clr_idx[FW-1:0];
      fo_wdata = '0;
    end else if (wload && !hit) begin
      fo_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing    <= 1'b1;
      clr_idx     <= '0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      vw          <= 1'b0;
      ov          <= 1'b0;
      inv_phase   <= 1'b0;
      victim      <= '0;
      fault_count <= '0;
      fwd_pm_hit  <= 1'b0;
      fwd_fo_hit  <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == CW'(CLR_N - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (adv) begin
        v1         <= lookup.valid;
        v2         <= v1;
        vw         <= v2;
        fwd_pm_hit <= pm_we && (pm_waddr == page_r);
        fwd_fo_hit <= fo_we && (fo_waddr == victim_rd);
      end
      if (wload && !hit) begin
        victim      <= victim_inc;
        fault_count <= fault_inc;
      end
      if (wload && evict) begin
        inv_phase <= 1'b1;
      end else if (vw && inv_phase) begin
        inv_phase <= 1'b0;
      end
      if (wload) begin
        ov <= 1'b1;
      end else if (result.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      off1        <= offset;
      off2        <= off1;
      offw        <= off2;
      page_w      <= page_r;
      fwd_pm_data <= pm_wdata;
      fwd_fo_data <= fo_wdata;
    end
    if (wload && evict) begin
      inv_page <= old_page;
    end
    if (wload) begin
      out_q.physical_address <= phys_wide[dpat_pkg::PHYS_W-1:0];
      out_q.page_fault       <= !hit;
      out_q.evicted_valid    <= evict;
      out_q.evicted_page     <= evict ? evict_wide[dpat_pkg::EVICT_W-1:0] : '0;
      out_q.fault_total      <= hit ? fault_count : fault_inc;
    end
  end

  assign lookup.ready = adv;
  assign result.valid = ov;
  assign result.data  = out_q;

  `ASSERT_IMPL(a_inv_needs_item, inv_phase, vw, "invalidate cycle without a lookup in flight")
  `ASSERT_IMPL(a_victim_range, 1'b1, int'(victim) < FRAME_COUNT, "victim pointer out of range")
  `ASSERT_IMPL(a_evict_other_page, wload && evict, old_page != page_w, "evicted page equals faulting page")
  `ASSERT_NEXT(a_evict_invalidates, wload && evict, inv_phase && pm_we, "eviction not followed by invalidate")
  `ASSERT_IMPL(a_count_monotonic, !$past(rst), fault_count >= $past(fault_count), "fault count decreased")

endmodule

// File: rtl/dpat_page_mod.sv
// Page number reduction modulo the page table depth.
// Two-stage reciprocal multiply with one final compare-subtract; uses dpat_pkg.
module dpat_page_mod #(
  parameter int PAGE_COUNT = 256,
  parameter int PW         = 8
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [dpat_pkg::ADDR_W-1:0] page_field,
  output logic [PW-1:0]              page
);

  localparam logic [63:0] RECIP64 = (64'd1 << 32) / 64'(PAGE_COUNT);
  localparam logic [31:0] RECIP   = RECIP64[31:0];
  localparam logic [17:0] PC18    = 18'(PAGE_COUNT);

  logic [dpat_pkg::ADDR_W-1:0] x1;
  logic [47:0]                 prod;
  logic [15:0]                 quot;
  logic [33:0]                 quot_pc;
  logic [17:0]                 rem_raw;

  assign quot    = prod[47:32];
  assign quot_pc = 34'(quot) * 34'(PC18);

  always_ff @(posedge clk) begin
    if (en) begin
      x1      <= page_field;
      prod    <= 48'(page_field) * 48'(RECIP);
      rem_raw <= 18'(34'(x1) - quot_pc);
    end
  end

  // quotient estimate is low by at most one
  assign page = (rem_raw >= PC18) ? PW'(rem_raw - PC18) : PW'(rem_raw);

endmodule

// File: rtl/dpat_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
module dpat_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 9,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: bench/demand_paged_address_translator_top_tb.sv
// Testbench for demand_paged_address_translator_top: drives logical addresses,
// predicts page-table hits, FIFO frame eviction and the saturating fault total.
// Depends on dpat_pkg, dpat_stream_if and the translator RTL.
module demand_paged_address_translator_top_tb;

  localparam int PAGES       = 256;
  localparam int FRAMES      = 128;
  localparam int OFFSET_W    = 8;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 20;

  logic clk;
  logic rst;

  dpat_stream_if #(.beat_t(dpat_pkg::lookup_t)) lookup_bus ();
  dpat_stream_if #(.beat_t(dpat_pkg::result_t)) result_bus ();

  demand_paged_address_translator_top #(
    .PAGE_COUNT(PAGES),
    .FRAME_COUNT(FRAMES),
    .OFFSET_WIDTH(OFFSET_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .lookup(lookup_bus),
    .result(result_bus)
  );

  // translation model state
  logic             page_live [PAGES];
  logic [6:0]       page_frame [PAGES];
  logic             frame_live [FRAMES];
  logic [7:0]       frame_page [FRAMES];
  logic [6:0]       next_victim;
  logic [dpat_pkg::COUNT_W-1:0] fault_tally;

  dpat_pkg::result_t pending_translations [$];
  dpat_pkg::result_t want;
  int      errors;
  int      quiet_cycles;
  int      stall_left;
  bit      gaps_on;
  bit      stalls_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic dpat_pkg::result_t translate_address(
      input logic [dpat_pkg::ADDR_W-1:0] addr);
    dpat_pkg::result_t r;
    logic [7:0] page;
    logic [6:0] frame;
    r = '0;
    page = addr[dpat_pkg::ADDR_W-1:OFFSET_W];
    if (page_live[page]) begin
      frame = page_frame[page];
    end else begin
      r.page_fault = 1'b1;
      if (fault_tally != dpat_pkg::COUNT_MAX) fault_tally = fault_tally + 1'b1;
      frame = next_victim;
      if (frame_live[frame]) begin
        r.evicted_valid = 1'b1;
        r.evicted_page = frame_page[frame];
        page_live[frame_page[frame]] = 1'b0;
      end
      page_live[page] = 1'b1;
      page_frame[page] = frame;
      frame_live[frame] = 1'b1;
      frame_page[frame] = page;
      next_victim = frame + 1'b1;
    end
    r.physical_address = {frame, addr[OFFSET_W-1:0]};
    r.fault_total = fault_tally;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_address(input logic [dpat_pkg::ADDR_W-1:0] addr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      lookup_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    lookup_bus.valid <= 1'b1;
    lookup_bus.data.logical_address <= addr;
    do @(posedge clk); while (!lookup_bus.ready);
    pending_translations.push_back(translate_address(addr));
  endtask

  task automatic wait_drained();
    lookup_bus.valid <= 1'b0;
    while (pending_translations.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string field, input logic [15:0] exp_val,
                             input logic [15:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, field, exp_val, got_val);
      errors++;
    end
  endtask

  // result side: random back-pressure while stalls_on is set, mostly short stalls; ready held high otherwise
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
      stall_left <= 0;
    end else if (!stalls_on) begin
      result_bus.ready <= 1'b1;
    end else if (stall_left > 0) begin
      result_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 20) begin
      result_bus.ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_translations.size() == 0) begin
        $display("%0t unexpected result beat: expected none, actual %h", $time,
                 result_bus.data);
        errors++;
      end else begin
        want = pending_translations.pop_front();
        check_field("physical_address", 16'(want.physical_address),
                    16'(result_bus.data.physical_address));
        check_field("page_fault", 16'(want.page_fault), 16'(result_bus.data.page_fault));
        check_field("evicted_valid", 16'(want.evicted_valid),
                    16'(result_bus.data.evicted_valid));
        check_field("evicted_page", 16'(want.evicted_page), 16'(result_bus.data.evicted_page));
        check_field("fault_total", want.fault_total, result_bus.data.fault_total);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (lookup_bus.valid && lookup_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_address(16'h0000);
    send_address(16'hFFFF);
    send_address(16'h00FF);
    send_address(16'hFF00);
    send_address(16'h8000);
    send_address(16'h7F80);
    send_address(16'h5555);
    send_address(16'hAAAA);
    send_address(16'h55AA);
    send_address(16'h8001);
    send_address(16'h0100);
    send_address(16'hFE7F);
  endtask

  // fill every frame, then wrap the victim pointer, evict a few pages and touch pages 00, FF and 00 again
  task automatic test_fifo_wrap();
    logic [7:0] page;
    int         evictions;
    page = 8'd1;
    evictions = 0;
    while (evictions < 12) begin
      while (page_live[page]) page = page + 1'b1;
      if (frame_live[next_victim]) evictions++;
      send_address({page, 8'($urandom)});
    end
    send_address({8'h00, 8'($urandom)});
    send_address({8'hFF, 8'($urandom)});
    send_address({8'h00, 8'($urandom)});
  endtask

  task automatic test_random(input int count);
    int         sent;
    int         burst;
    int         span;
    logic [7:0] base;
    logic [dpat_pkg::ADDR_W-1:0] addr;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(20, 80);
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: span = 8;
        1: span = 100;
        2: span = 160;
        default: span = 256;
      endcase
      base = 8'($urandom);
      for (int i = 0; i < burst && sent < count; i++) begin
        if ($urandom_range(0, 9) == 0) addr = 16'($urandom);
        else addr = {8'(base + $urandom_range(0, span - 1)), 8'($urandom)};
        send_address(addr);
        sent++;
      end
    end
  endtask

  task automatic test_pause_drain();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    for (int i = 0; i < 30; i++) send_address(16'($urandom));
    wait_drained();
    for (int i = 0; i < 30; i++) send_address(16'($urandom));
  endtask

  // walk consecutive pages, first with no idling on either side, then with idling
  task automatic test_fault_streak();
    logic [7:0] page;
    page = 8'($urandom);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    for (int i = 0; i < 60; i++) begin
      send_address({page, 8'($urandom)});
      page = page + 1'b1;
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_address({page, 8'($urandom)});
      page = page + 1'b1;
    end
    send_address({8'(page - 1'b1), 8'($urandom)});
  endtask

  initial begin
    rst = 1'b1;
    errors = 0;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    lookup_bus.valid <= 1'b0;
    lookup_bus.data <= '0;
    for (int p = 0; p < PAGES; p++) begin
      page_live[p] = 1'b0;
      page_frame[p] = '0;
    end
    for (int f = 0; f < FRAMES; f++) begin
      frame_live[f] = 1'b0;
      frame_page[f] = '0;
    end
    next_victim = '0;
    fault_tally = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    test_fifo_wrap();
    test_random(1040);
    test_pause_drain();
    test_fault_streak();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
